// File: rtl/core/fsb_pkg.sv
// Shared types and constants for the forwarding scoreboard.
package fsb_pkg;

   localparam int NUM_REGS = 34;
   localparam int REG_IDX_W = 6;
   localparam int STAGE_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_HI = 6'd32;
   localparam logic [REG_IDX_W-1:0] REG_LO = 6'd33;
   localparam logic [REG_IDX_W-1:0] REG_HILO = 6'd34;

   localparam logic [1:0] CMD_ISSUE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [REG_IDX_W-1:0] dst_reg;
      logic is_load;
      logic is_cond_move;
      logic [REG_IDX_W-1:0] query_a;
      logic [REG_IDX_W-1:0] query_b;
   } req_payload_type;

   typedef struct packed {
      logic a_bypassable;
      logic [STAGE_W-1:0] a_stage;
      logic b_bypassable;
      logic [STAGE_W-1:0] b_stage;
      logic hi_from_divmult;
   } rsp_payload_type;

   typedef struct packed {
      logic issue;
      logic cancel;
      logic tick;
      logic [STAGE_W-1:0] ready_at;
   } entry_ctl_type;

endpackage

// File: rtl/core/fsb_if.sv
// Valid/ready channel interfaces for the forwarding scoreboard.
interface fsb_req_if
   import fsb_pkg::*;
   ();
   logic valid;
   logic ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fsb_rsp_if
   import fsb_pkg::*;
   ();
   logic valid;
   logic ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/fsb_entry.sv
// One scoreboard entry: stage counter, ready stage and bypass flag of a register.
module fsb_entry
   import fsb_pkg::*;
#(
   parameter int LAST_STAGE = 2
) (
   input logic clock,
   input logic reset,
   input entry_ctl_type ctl,
   output logic [STAGE_W-1:0] stage_in,
   output logic bypass_in
);

   localparam logic [STAGE_W-1:0] LAST = STAGE_W'(LAST_STAGE);
   localparam logic [STAGE_W-1:0] IN_RF = STAGE_W'(LAST_STAGE + 1);

   logic [STAGE_W-1:0] stage_ff;
   logic [STAGE_W-1:0] ready_ff;
   logic [STAGE_W-1:0] ready_in;
   logic bypass_ff;
   logic [STAGE_W-1:0] stage_inc;

   assign stage_inc = stage_ff + STAGE_W'(1);

   always_comb begin
      stage_in = stage_ff;
      ready_in = ready_ff;
      bypass_in = bypass_ff;
      if (ctl.issue) begin
         stage_in = '0;
         ready_in = ctl.ready_at;
         bypass_in = (ctl.ready_at == '0);
      end else if (ctl.cancel) begin
         stage_in = IN_RF;
         bypass_in = 1'b0;
      end else if (ctl.tick && stage_ff <= LAST) begin
         if (stage_ff == LAST) begin
            stage_in = IN_RF;
            bypass_in = 1'b0;
         end else begin
            stage_in = stage_inc;
            if (stage_inc == ready_ff) begin
               bypass_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= IN_RF;
         ready_ff <= '0;
         bypass_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         ready_ff <= ready_in;
         bypass_ff <= bypass_in;
      end
   end

endmodule

// File: rtl/core/forwarding_scoreboard_top.sv
// Top level of the forwarding scoreboard with its result register.
// The scoreboard tracks 32 general registers plus HI and LO. Every item carries
// one command (issue, tick or cancel) and two source queries; it is applied to
// the state and the queries are answered from the updated state, so each item
// yields exactly one result, presented in the next cycle. An item is accepted
// in every cycle while the result register is empty or being drained, giving a
// sustained rate of one item per cycle, set by the single result register.
// A stage value of LAST_STAGE+1 means the value sits in the register file.
module forwarding_scoreboard_top
   import fsb_pkg::*;
#(
   parameter int LAST_STAGE = 2
) (
   input logic clock,
   input logic reset,
   fsb_req_if.sink req_ch,
   fsb_rsp_if.source rsp_ch
);

   localparam logic [STAGE_W-1:0] IN_RF = STAGE_W'(LAST_STAGE + 1);

   logic accept;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;
   logic hi_flag_ff;
   logic hi_flag_in;
   logic [STAGE_W-1:0] issue_ready_at;
   logic is_issue;
   logic is_cancel;
   logic is_tick;
   req_payload_type req;

   entry_ctl_type ctl [NUM_REGS];
   logic [STAGE_W-1:0] stage_nx [NUM_REGS];
   logic bypass_nx [NUM_REGS];

   assign req = req_ch.payload;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   assign is_issue = accept && (req.command == CMD_ISSUE);
   assign is_cancel = accept && (req.command == CMD_CANCEL);
   assign is_tick = accept && (req.command == CMD_TICK);
   assign issue_ready_at = req.is_cond_move ? IN_RF
                         : (req.is_load ? STAGE_W'(1) : STAGE_W'(0));

   for (genvar r = 0; r < NUM_REGS; r++) begin : g_entry
      logic hit;
      if (r == 0) begin : g_zero
         assign hit = 1'b0;
      end else if (r == int'(REG_HI) || r == int'(REG_LO)) begin : g_hilo
         assign hit = (req.dst_reg == REG_IDX_W'(r)) || (req.dst_reg == REG_HILO);
      end else begin : g_gpr
         assign hit = (req.dst_reg == REG_IDX_W'(r));
      end
      assign ctl[r].issue = is_issue && hit;
      assign ctl[r].cancel = is_cancel && hit;
      assign ctl[r].tick = is_tick;
      assign ctl[r].ready_at = issue_ready_at;

      fsb_entry #(
         .LAST_STAGE(LAST_STAGE)
      ) u_entry (
         .clock(clock),
         .reset(reset),
         .ctl(ctl[r]),
         .stage_in(stage_nx[r]),
         .bypass_in(bypass_nx[r])
      );
   end

   always_comb begin
      hi_flag_in = hi_flag_ff;
      if (is_issue && req.dst_reg == REG_HILO) begin
         hi_flag_in = 1'b1;
      end else if (is_issue && req.dst_reg == REG_LO) begin
         hi_flag_in = 1'b0;
      end
   end

   always_comb begin
      rsp_payload_in.a_bypassable = 1'b0;
      rsp_payload_in.a_stage = IN_RF;
      rsp_payload_in.b_bypassable = 1'b0;
      rsp_payload_in.b_stage = IN_RF;
      rsp_payload_in.hi_from_divmult = hi_flag_in;
      if (req.query_a < REG_IDX_W'(NUM_REGS)) begin
         rsp_payload_in.a_bypassable = bypass_nx[req.query_a];
         rsp_payload_in.a_stage = stage_nx[req.query_a];
      end
      if (req.query_b < REG_IDX_W'(NUM_REGS)) begin
         rsp_payload_in.b_bypassable = bypass_nx[req.query_b];
         rsp_payload_in.b_stage = stage_nx[req.query_b];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hi_flag_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hi_flag_ff <= hi_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

endmodule
